// ===== hw/rtl/lru_page_replacement_working_set_unit_macros.svh =====
// Assertion macros used by the checker file of the working-set unit.
`ifndef LRU_PAGE_REPLACEMENT_WORKING_SET_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_WORKING_SET_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LRUWS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lruws: implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LRUWS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lruws: next-cycle check failed");

`endif

// ===== hw/rtl/lruws_pkg.sv =====
// Types and constants of the LRU working-set unit.
`timescale 1ns / 1ps
package lruws_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = 7;
	localparam int PID_W      = 5;
	localparam int PAGE_W     = 4;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(4);

	// register word index (paddr[2])
	localparam logic REG_WS_LIMIT = 1'b0;

	// outcome codes
	localparam logic [1:0] OUT_HIT     = 2'd0;
	localparam logic [1:0] OUT_FAULT   = 2'd1;
	localparam logic [1:0] OUT_REPLACE = 2'd2;
	localparam logic [1:0] OUT_DROPPED = 2'd3;

	typedef struct packed {
		logic [PID_W-1:0]  process_id;
		logic [PAGE_W-1:0] page_number;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        outcome;
		logic [PAGE_W-1:0] evicted_page;
		logic [CNT_W-1:0]  resident_count;
	} out_item_t;

	// one list entry
	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [PAGE_W-1:0] page;
	} entry_t;

	// sequencer to scan unit
	typedef struct packed {
		logic             clear;
		logic             step;
		entry_t           entry;
		logic [IDX_W-1:0] pos;
	} scan_ctl_t;

	// scan unit accumulators
	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  hit_pos;
		logic              pid_seen;
		logic [IDX_W-1:0]  old_pos;
		logic [PAGE_W-1:0] old_page;
		logic [CNT_W-1:0]  count;
	} scan_res_t;

endpackage

// ===== hw/rtl/lruws_scan.sv =====
// Compare-and-count unit: takes one list entry a cycle while step is set and accumulates match info.
`timescale 1ns / 1ps
module lruws_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  lruws_pkg::entry_t    key,
	input  lruws_pkg::scan_ctl_t ctl,
	output lruws_pkg::scan_res_t res
);
	import lruws_pkg::*;

	scan_res_t res_q;
	logic      pid_match;
	logic      full_match;

	// shared comparator
	assign pid_match  = (ctl.entry.pid == key.pid);
	assign full_match = pid_match && (ctl.entry.page == key.page);

	// accumulate first hit, oldest entry of the process and its count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (ctl.clear) begin
			res_q <= '0;
		end else if (ctl.step) begin
			if (full_match && !res_q.hit) begin
				res_q.hit     <= 1'b1;
				res_q.hit_pos <= ctl.pos;
			end
			if (pid_match) begin
				res_q.count <= res_q.count + CNT_W'(1);
				if (!res_q.pid_seen) begin
					res_q.pid_seen <= 1'b1;
					res_q.old_pos  <= ctl.pos;
					res_q.old_page <= ctl.entry.page;
				end
			end
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/lru_page_replacement_working_set_unit.sv =====
// Sequence: a scan of the used entries, a decide step, then for a hit or replacement a
// close-up shift of the entries behind the matched or oldest position, one write step
// (skipped when the reference is dropped) and a result step.
// Throughput: one reference at a time; the list memory port (one read, one write a cycle)
// sets the pace. A finished result waits in an output register while the next is taken.
// Reset: list empty (fill count zero), limit 4, no result pending; no clearing pass.
`timescale 1ns / 1ps
module lru_page_replacement_working_set_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// reference channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lruws_pkg::in_item_t           in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output lruws_pkg::out_item_t          out_data,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lruws_pkg::APB_AW-1:0]  paddr,
	input  logic [lruws_pkg::APB_DW-1:0]  pwdata,
	output logic [lruws_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import lruws_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_WRITE,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] used_q;
	entry_t           key_q;
	logic [CNT_W-1:0] issue_idx_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_pos_q;
	logic [IDX_W-1:0] app_addr_q;
	logic             grow_q;
	out_item_t        res_q;
	out_item_t        out_q;
	logic             out_valid_q;

	entry_t           mem [LIST_DEPTH];
	entry_t           rd_data_q;

	logic             in_acc;
	logic             out_acc;
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic [CNT_W-1:0] limit_eff;
	scan_ctl_t        scan_ctl;
	scan_res_t        scan_res;

	// handshakes
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WS_LIMIT) ? APB_DW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_WS_LIMIT) begin
			limit_q <= pwdata[CNT_W-1:0];
		end
	end

	// a limit of zero acts as one
	assign limit_eff = (limit_q == '0) ? CNT_W'(1) : limit_q;

	// list memory read side: one entry per cycle while scanning or shifting
	assign issue   = (state_q == S_SCAN || state_q == S_SHIFT) && (issue_idx_q < used_q);
	assign rd_addr = issue_idx_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// list memory write side: shift down by one, or append the key
	always_comb begin
		we      = 1'b0;
		wr_addr = app_addr_q;
		wr_data = key_q;
		if (state_q == S_SHIFT && rd_vld_q) begin
			we      = 1'b1;
			wr_addr = rd_pos_q - IDX_W'(1);
			wr_data = rd_data_q;
		end else if (state_q == S_WRITE) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// scan unit drive
	always_comb begin
		scan_ctl.clear = in_acc;
		scan_ctl.step  = (state_q == S_SCAN) && rd_vld_q;
		scan_ctl.entry = rd_data_q;
		scan_ctl.pos   = rd_pos_q;
	end

	lruws_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_q),
		.ctl    (scan_ctl),
		.res    (scan_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			issue_idx_q <= '0;
			rd_vld_q    <= 1'b0;
			rd_pos_q    <= '0;
			app_addr_q  <= '0;
			grow_q      <= 1'b0;
			out_valid_q <= 1'b0;
			key_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end

			// read pipeline tracking
			if (issue) begin
				issue_idx_q <= issue_idx_q + CNT_W'(1);
				rd_pos_q    <= issue_idx_q[IDX_W-1:0];
			end
			rd_vld_q <= issue;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						key_q.pid   <= in_data.process_id;
						key_q.page  <= in_data.page_number;
						issue_idx_q <= '0;
						rd_vld_q    <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!issue && !rd_vld_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					res_q.evicted_page   <= '0;
					res_q.resident_count <= scan_res.count;
					grow_q               <= 1'b0;
					rd_vld_q             <= 1'b0;
					app_addr_q           <= IDX_W'(used_q - CNT_W'(1));
					if (scan_res.hit) begin
						res_q.outcome <= OUT_HIT;
						issue_idx_q   <= CNT_W'(scan_res.hit_pos) + CNT_W'(1);
						state_q       <= S_SHIFT;
					end else if (scan_res.count >= limit_eff) begin
						res_q.outcome      <= OUT_REPLACE;
						res_q.evicted_page <= scan_res.old_page;
						issue_idx_q        <= CNT_W'(scan_res.old_pos) + CNT_W'(1);
						state_q            <= S_SHIFT;
					end else if (used_q == CNT_W'(LIST_DEPTH)) begin
						res_q.outcome <= OUT_DROPPED;
						state_q       <= S_FINISH;
					end else begin
						res_q.outcome        <= OUT_FAULT;
						res_q.resident_count <= scan_res.count + CNT_W'(1);
						app_addr_q           <= used_q[IDX_W-1:0];
						grow_q               <= 1'b1;
						state_q              <= S_WRITE;
					end
				end
				S_SHIFT: begin
					if (!issue && !rd_vld_q) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (grow_q) begin
						used_q <= used_q + CNT_W'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/lruws_checker.sv =====
// Port-level checker for the working-set unit, bound to the top level.
`timescale 1ns / 1ps
`include "lru_page_replacement_working_set_unit_macros.svh"
module lruws_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input lruws_pkg::in_item_t          in_data,
	input logic                         out_valid,
	input logic                         out_stall,
	input lruws_pkg::out_item_t         out_data,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [lruws_pkg::APB_AW-1:0] paddr,
	input logic [lruws_pkg::APB_DW-1:0] pwdata,
	input logic [lruws_pkg::APB_DW-1:0] prdata,
	input logic                         pready
);
	import lruws_pkg::*;

	// a pending result is held until taken
	`LRUWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// the unit is busy right after taking a reference
	`LRUWS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// no result can come out the cycle after a reference is taken
	`LRUWS_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid, !out_valid)

	// only a replacement reports an evicted page; a stored fault leaves at least one page
	`LRUWS_ASSERT_IMPL(a_result_shape,
		out_valid && out_data.outcome != OUT_REPLACE, out_data.evicted_page == '0)
	`LRUWS_ASSERT_IMPL(a_fault_count,
		out_valid && out_data.outcome == OUT_FAULT, out_data.resident_count != '0)

endmodule

bind lru_page_replacement_working_set_unit lruws_checker u_lruws_checker (.*);
